// ===== src/fcd_pkg.sv =====
// shared constants and types of the frame change detector
package fcd_pkg;

    // frame geometry
    localparam int MAX_PIXELS   = 4096;
    localparam int REGION_COUNT = 4;
    localparam int REGION_W     = 2;
    localparam int POS_W        = $clog2(MAX_PIXELS + 1);
    localparam int PIX_ADDR_W   = $clog2(MAX_PIXELS);
    localparam int STORE_ADDR_W = REGION_W + PIX_ADDR_W;

    // pixel word in the store: blue, green, red
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int THR_W      = 17;
    localparam int MASK_W     = 4;

    // gray conversion, 14-bit fixed point
    localparam logic [12:0] COEF_R     = 13'd4899;
    localparam logic [13:0] COEF_G     = 14'd9617;
    localparam logic [10:0] COEF_B     = 11'd1868;
    localparam logic [13:0] GRAY_ROUND = 14'd8192;
    localparam int          GRAY_SHIFT = 14;
    localparam int          PROD_R_W   = CHAN_W + 13;
    localparam int          PROD_G_W   = CHAN_W + 14;
    localparam int          PROD_B_W   = CHAN_W + 11;
    localparam int          GRAY_SUM_W = 24;
    localparam logic [GRAY_SUM_W-GRAY_SHIFT-1:0] GRAY_LIMIT = 10'd30;

    // ratio test
    localparam int RATIO_SHIFT = 16;
    localparam int RATIO_W     = THR_W + POS_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE_MASK = 3'd0,
        REG_THRESHOLD0  = 3'd1,
        REG_THRESHOLD1  = 3'd2,
        REG_THRESHOLD2  = 3'd3,
        REG_THRESHOLD3  = 3'd4
    } cfg_reg_t;

    // control that travels with a pixel down the pipeline
    typedef struct packed {
        logic                compare;
        logic                eof;
        logic                has_ref;
        logic [REGION_W-1:0] region;
        logic [POS_W-1:0]    total;
        logic [THR_W-1:0]    threshold;
    } pix_ctrl_t;

endpackage

// ===== src/fcd_frame_ram.sv =====
// single-port frame store, read-before-write, registered read data
module fcd_frame_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata <= mem[addr];
            if (we) begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

// ===== src/frame_change_detector_unit.sv =====
// frame change detector top level: pixel pipeline, frame store and result register
//
// an end_of_frame item passes through the pipeline stages and then the result register to m_valid
// throughput: 1 item per cycle while not stalled; the frame store is read and written in the accept cycle
// back-pressure: input stalls only while a finished result waits in the output register
// and the next frame's result has reached the last stage
// reset: aresetn clears control, counters, history and config; the frame store is not cleared
module frame_change_detector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fcd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // pixel items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fcd_pkg::REGION_W-1:0]     s_region,
    input  logic [fcd_pkg::CHAN_W-1:0]       s_blue,
    input  logic [fcd_pkg::CHAN_W-1:0]       s_green,
    input  logic [fcd_pkg::CHAN_W-1:0]       s_red,
    input  logic                             s_end_of_frame,
    // frame result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_changed,
    output logic [fcd_pkg::POS_W-1:0]        m_changed_pixels,
    output logic [fcd_pkg::POS_W-1:0]        m_total_pixels,
    output logic [fcd_pkg::REGION_W-1:0]     m_reported_region,
    output logic                             m_no_reference
);
    import fcd_pkg::*;

    // configuration state
    logic [MASK_W-1:0] enable_mask_reg;
    logic [THR_W-1:0]  threshold_reg [REGION_COUNT];

    // frame tracking state: per-region history bits, and a position shared by all regions
    logic [MASK_W-1:0] history_valid_reg;
    logic [POS_W-1:0]  pos_reg;

    // pipeline
    logic              adv;
    logic              accept;
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    pix_ctrl_t         p1_ctrl_reg, p2_ctrl_reg, p3_ctrl_reg;
    pix_ctrl_t         p0_ctrl;
    logic [PIXEL_W-1:0] p1_pixel_reg;
    logic [PIXEL_W-1:0] ref_pixel;

    logic [PROD_R_W-1:0] p2_prod_r_reg;
    logic [PROD_G_W-1:0] p2_prod_g_reg;
    logic [PROD_B_W-1:0] p2_prod_b_reg;

    logic [POS_W-1:0]   cnt_reg;
    logic [POS_W-1:0]   cnt_next;
    logic [POS_W-1:0]   p3_count_reg;
    logic [RATIO_W-1:0] p3_thr_prod_reg;

    logic              out_valid_reg;
    logic              out_changed_reg;
    logic [POS_W-1:0]  out_count_reg;
    logic [POS_W-1:0]  out_total_reg;
    logic [REGION_W-1:0] out_region_reg;
    logic              out_no_ref_reg;

    // accept-stage decode
    logic              in_range;
    logic              enabled;
    logic              has_ref;
    logic              pos_open;
    logic              store_we;
    logic [STORE_ADDR_W-1:0] store_addr;
    logic [POS_W-1:0]  pos_inc;

    // difference stage
    logic [CHAN_W-1:0] old_b, old_g, old_r;
    logic [CHAN_W-1:0] dif_b, dif_g, dif_r;

    // gray and count stage
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic                  hit;
    logic [POS_W-1:0]      cnt_acc;
    logic [RATIO_W-1:0]    thr_prod;

    // ratio stage
    logic [RATIO_W-1:0] count_scaled;
    logic               frame_changed;
    logic               load_out;

    // the whole pipeline only halts when a result is ready to leave the last
    // stage and the output register is still held
    assign load_out = p3_valid_reg && p3_ctrl_reg.eof;
    assign adv      = !(load_out && out_valid_reg && !m_ready);
    assign s_ready  = adv;
    assign accept   = s_valid && adv;

    // region status at the accept edge
    assign in_range = (32'(s_region) < REGION_COUNT);
    assign enabled  = in_range && enable_mask_reg[s_region];
    assign has_ref  = enabled && history_valid_reg[s_region];
    assign pos_open = (pos_reg < POS_W'(MAX_PIXELS));
    assign pos_inc  = pos_open ? pos_reg + 1'b1 : pos_reg;

    // pixels past the frame limit or of an unknown region leave the store alone
    assign store_we   = accept && in_range && pos_open;
    assign store_addr = {s_region, pos_reg[PIX_ADDR_W-1:0]};

    always_comb begin
        p0_ctrl.compare   = in_range && pos_open && has_ref;
        p0_ctrl.eof       = s_end_of_frame;
        p0_ctrl.has_ref   = has_ref;
        p0_ctrl.region    = s_region;
        p0_ctrl.total     = pos_inc;
        p0_ctrl.threshold = threshold_reg[s_region];
    end

    // read the old pixel and store the new one in the same access
    fcd_frame_ram #(
        .DATA_W (PIXEL_W),
        .ADDR_W (STORE_ADDR_W)
    ) u_frame_ram (
        .aclk  (aclk),
        .en    (accept),
        .we    (store_we),
        .addr  (store_addr),
        .wdata ({s_blue, s_green, s_red}),
        .rdata (ref_pixel)
    );

    // configuration registers and per-region history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg   <= '0;
            history_valid_reg <= '0;
            for (int i = 0; i < REGION_COUNT; i++) begin
                threshold_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ENABLE_MASK: begin
                        enable_mask_reg   <= cfg_wdata[MASK_W-1:0];
                        // disabling a region drops its reference frame
                        history_valid_reg <= history_valid_reg & cfg_wdata[MASK_W-1:0];
                    end
                    REG_THRESHOLD0: threshold_reg[0] <= cfg_wdata[THR_W-1:0];
                    REG_THRESHOLD1: threshold_reg[1] <= cfg_wdata[THR_W-1:0];
                    REG_THRESHOLD2: threshold_reg[2] <= cfg_wdata[THR_W-1:0];
                    REG_THRESHOLD3: threshold_reg[3] <= cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end else if (accept && s_end_of_frame && enabled) begin
                // finished frame becomes this region's reference
                history_valid_reg[s_region] <= 1'b1;
            end
        end
    end

    // pixel position within the current frame, saturating at the limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= s_end_of_frame ? '0 : pos_inc;
        end
    end

    // stage 1: reference pixel arrives from the store, take channel differences
    assign old_b = ref_pixel[3*CHAN_W-1:2*CHAN_W];
    assign old_g = ref_pixel[2*CHAN_W-1:CHAN_W];
    assign old_r = ref_pixel[CHAN_W-1:0];

    assign dif_b = (old_b > p1_pixel_reg[3*CHAN_W-1:2*CHAN_W])
                 ? old_b - p1_pixel_reg[3*CHAN_W-1:2*CHAN_W]
                 : p1_pixel_reg[3*CHAN_W-1:2*CHAN_W] - old_b;
    assign dif_g = (old_g > p1_pixel_reg[2*CHAN_W-1:CHAN_W])
                 ? old_g - p1_pixel_reg[2*CHAN_W-1:CHAN_W]
                 : p1_pixel_reg[2*CHAN_W-1:CHAN_W] - old_g;
    assign dif_r = (old_r > p1_pixel_reg[CHAN_W-1:0])
                 ? old_r - p1_pixel_reg[CHAN_W-1:0]
                 : p1_pixel_reg[CHAN_W-1:0] - old_r;

    // stage 2: gray of the difference, changed-pixel count, threshold product
    assign gray_sum = GRAY_SUM_W'(p2_prod_r_reg) + GRAY_SUM_W'(p2_prod_g_reg)
                    + GRAY_SUM_W'(p2_prod_b_reg) + GRAY_SUM_W'(GRAY_ROUND);
    assign hit      = p2_ctrl_reg.compare
                    && (gray_sum[GRAY_SUM_W-1:GRAY_SHIFT] > GRAY_LIMIT);
    assign cnt_acc  = cnt_reg + POS_W'(hit);
    assign cnt_next = p2_ctrl_reg.eof ? '0 : cnt_acc;
    assign thr_prod = RATIO_W'(p2_ctrl_reg.threshold) * RATIO_W'(p2_ctrl_reg.total);

    // stage 3: changed when count / total exceeds threshold, without dividing
    assign count_scaled  = RATIO_W'({p3_count_reg, {RATIO_SHIFT{1'b0}}});
    assign frame_changed = p3_ctrl_reg.has_ref && (count_scaled > p3_thr_prod_reg);

    // pipeline valid bits and counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (p2_valid_reg) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_ctrl_reg   <= p0_ctrl;
            p1_pixel_reg  <= {s_blue, s_green, s_red};
            p2_ctrl_reg   <= p1_ctrl_reg;
            p2_prod_r_reg <= PROD_R_W'(dif_r) * PROD_R_W'(COEF_R);
            p2_prod_g_reg <= PROD_G_W'(dif_g) * PROD_G_W'(COEF_G);
            p2_prod_b_reg <= PROD_B_W'(dif_b) * PROD_B_W'(COEF_B);
            p3_ctrl_reg     <= p2_ctrl_reg;
            p3_count_reg    <= p2_ctrl_reg.has_ref ? cnt_acc : '0;
            p3_thr_prod_reg <= thr_prod;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && load_out) begin
            out_changed_reg <= frame_changed;
            out_count_reg   <= p3_count_reg;
            out_total_reg   <= p3_ctrl_reg.total;
            out_region_reg  <= p3_ctrl_reg.region;
            out_no_ref_reg  <= !p3_ctrl_reg.has_ref;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_changed         = out_changed_reg;
    assign m_changed_pixels  = out_count_reg;
    assign m_total_pixels    = out_total_reg;
    assign m_reported_region = out_region_reg;
    assign m_no_reference    = out_no_ref_reg;

`ifndef NO_ASSERTIONS
    // a region never keeps a reference while it is disabled
    a_history_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (history_valid_reg & ~enable_mask_reg) == '0)
        else $error("history valid for a disabled region");

    // frame position never runs past the store depth
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_PIXELS))
        else $error("pixel position beyond frame limit");

    // a frame without reference reports nothing changed
    a_no_ref_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_no_ref_reg |-> !out_changed_reg && out_count_reg == '0)
        else $error("change reported without reference frame");

    // changed pixels never outnumber the pixels seen
    a_count_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_count_reg <= out_total_reg)
        else $error("changed pixel count exceeds total");

    // a held result stalls the pipeline only when another result is waiting behind it
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> p3_valid_reg && p3_ctrl_reg.eof && out_valid_reg)
        else $error("pipeline stalled without a pending result");
`endif

endmodule
